### design/sprite_subtile_packer_defines.svh
// ----------------------------------------------------------------------------
// Sprite subtile packer assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SPRITE_SUBTILE_PACKER_DEFINES_SVH
`define SPRITE_SUBTILE_PACKER_DEFINES_SVH

// same-cycle implication
`define SSP_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SSP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/ssp_pkg.sv
// ----------------------------------------------------------------------------
// Sprite subtile packer package
// Widths, register indexes and shared types.
// ----------------------------------------------------------------------------
package ssp_pkg;

	localparam int OUT_ADDR_BITS = 20;
	localparam int INDEX_BYTES   = 16384;
	localparam int IDX_ADDR_BITS = $clog2(INDEX_BYTES);
	localparam int ROW_WORDS     = 128;
	localparam int SUB_DIM       = 16;
	localparam int BAND_SHIFT    = $clog2(ROW_WORDS * SUB_DIM);
	localparam int SLOT_SHIFT    = $clog2(SUB_DIM);
	localparam int ROW_SHIFT     = $clog2(ROW_WORDS);
	localparam int CFG_IDX_BITS  = 4;

	localparam logic [31:0] KEY_RESET = 32'hFFFF00FF;

	typedef logic [OUT_ADDR_BITS-1:0] addr_t;
	typedef logic [IDX_ADDR_BITS-1:0] iaddr_t;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_TILES_ACROSS = 4'd0,
		REG_TILES_DOWN   = 4'd1,
		REG_SIZE_CODE    = 4'd2,
		REG_KEY_COLOUR   = 4'd3
	} reg_idx_t;

	typedef struct packed {
		logic [3:0]  tiles_across;
		logic [3:0]  tiles_down;
		logic [1:0]  size_code;
		logic [31:0] key_colour;
	} cfg_t;

	// walker position and per-pixel decisions
	typedef struct packed {
		logic [3:0]  pix_col;
		logic [3:0]  pix_row;
		logic [3:0]  sub_col;
		logic [3:0]  sub_row;
		logic [15:0] frame_count;
		logic [6:0]  slot_count;
		logic [1:0]  size_code;
		logic        has_slot;
		logic        keep;
		logic        drop;
		logic        frame_done;
	} step_t;

	typedef struct packed {
		addr_t       pix_addr;
		logic [31:0] pix_data;
		logic        pix_write;
		iaddr_t      idx_addr;
		logic [7:0]  idx_byte;
		logic        idx_write;
		logic        dropped;
		logic        frame_end;
	} result_t;

endpackage

### design/ssp_if.sv
// ----------------------------------------------------------------------------
// Sprite subtile packer channels
// Pixel input, write-result output and register write channels.
// ----------------------------------------------------------------------------
interface ssp_pix_if;
	logic        valid;
	logic        ready;
	logic [31:0] pixel;

	modport source (output valid, output pixel, input ready);
	modport sink   (input valid, input pixel, output ready);
endinterface

interface ssp_res_if;
	logic               valid;
	logic               ready;
	ssp_pkg::addr_t     pix_addr;
	logic [31:0]        pix_data;
	logic               pix_write;
	ssp_pkg::iaddr_t    idx_addr;
	logic [7:0]         idx_byte;
	logic               idx_write;
	logic               dropped;
	logic               frame_end;

	modport source (output valid, output pix_addr, output pix_data, output pix_write,
		output idx_addr, output idx_byte, output idx_write, output dropped,
		output frame_end, input ready);
	modport sink   (input valid, input pix_addr, input pix_data, input pix_write,
		input idx_addr, input idx_byte, input idx_write, input dropped,
		input frame_end, output ready);
endinterface

interface ssp_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [ssp_pkg::CFG_IDX_BITS-1:0] reg_index;
	logic [31:0]                      wr_data;

	modport source (output valid, output reg_index, output wr_data, input ready);
	modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

### design/ssp_cfg_regs.sv
// ----------------------------------------------------------------------------
// Sprite subtile packer register file
// Takes register write beats; indexes beyond the list are ignored.
// ----------------------------------------------------------------------------
module ssp_cfg_regs (
	input  logic          clk,
	input  logic          arst_n,
	ssp_cfg_if.sink       cfg,
	output ssp_pkg::cfg_t regs
);

	ssp_pkg::cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.tiles_across <= 4'd1;
			regs_q.tiles_down   <= 4'd1;
			regs_q.size_code    <= 2'd0;
			regs_q.key_colour   <= ssp_pkg::KEY_RESET;
		end else if (cfg.valid) begin
			case (cfg.reg_index)
				ssp_pkg::REG_TILES_ACROSS: regs_q.tiles_across <= cfg.wr_data[3:0];
				ssp_pkg::REG_TILES_DOWN:   regs_q.tiles_down   <= cfg.wr_data[3:0];
				ssp_pkg::REG_SIZE_CODE:    regs_q.size_code    <= cfg.wr_data[1:0];
				ssp_pkg::REG_KEY_COLOUR:   regs_q.key_colour   <= cfg.wr_data;
				default: ;
			endcase
		end
	end

endmodule

### design/ssp_track.sv
// ----------------------------------------------------------------------------
// Sprite subtile packer position tracker
// Pixel/subtile/frame counters, slot counter and keep/drop decisions.
// ----------------------------------------------------------------------------
`include "sprite_subtile_packer_defines.svh"

module ssp_track (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           accept,
	input  logic [31:0]    pixel,
	input  ssp_pkg::cfg_t  regs,
	output ssp_pkg::step_t step
);

	logic [3:0]  pix_col_q, pix_row_q, sub_col_q, sub_row_q;
	logic [15:0] frame_count_q;
	logic [6:0]  slot_count_q;
	logic        seen_opaque_q;

	logic [6:0] limit;
	logic       has_slot, opaque, last_pix, last_col, last_row, keep, drop;

	assign limit    = 7'd8 << regs.size_code;
	assign has_slot = slot_count_q < limit;
	assign opaque   = seen_opaque_q | (pixel != regs.key_colour);
	assign last_pix = (&pix_col_q) & (&pix_row_q);
	assign last_col = sub_col_q == (regs.tiles_across - 4'd1);
	assign last_row = sub_row_q == (regs.tiles_down - 4'd1);
	assign keep     = last_pix & opaque & has_slot;
	assign drop     = last_pix & opaque & ~has_slot;

	always_comb begin
		step.pix_col     = pix_col_q;
		step.pix_row     = pix_row_q;
		step.sub_col     = sub_col_q;
		step.sub_row     = sub_row_q;
		step.frame_count = frame_count_q;
		step.slot_count  = slot_count_q;
		step.size_code   = regs.size_code;
		step.has_slot    = has_slot;
		step.keep        = keep;
		step.drop        = drop;
		step.frame_done  = last_pix & last_col & last_row;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_col_q     <= '0;
			pix_row_q     <= '0;
			sub_col_q     <= '0;
			sub_row_q     <= '0;
			frame_count_q <= '0;
			slot_count_q  <= '0;
			seen_opaque_q <= 1'b0;
		end else if (accept) begin
			if (!last_pix) begin
				seen_opaque_q <= opaque;
				pix_col_q     <= pix_col_q + 4'd1;
				if (&pix_col_q) begin
					pix_row_q <= pix_row_q + 4'd1;
				end
			end else begin
				pix_col_q     <= '0;
				pix_row_q     <= '0;
				seen_opaque_q <= 1'b0;
				if (last_col) begin
					sub_col_q <= '0;
					if (last_row) begin
						sub_row_q     <= '0;
						frame_count_q <= frame_count_q + 16'd1;
						slot_count_q  <= '0;
					end else begin
						sub_row_q <= sub_row_q + 4'd1;
						if (keep) begin
							slot_count_q <= slot_count_q + 7'd1;
						end
					end
				end else begin
					sub_col_q <= sub_col_q + 4'd1;
					if (keep) begin
						slot_count_q <= slot_count_q + 7'd1;
					end
				end
			end
		end
	end

	`SSP_ASSERT_NOW(a_keep_drop_excl, 1'b1, !(keep && drop), "keep and drop both set")
	`SSP_ASSERT_NEXT(a_frame_wrap, accept && last_pix && last_col && last_row,
		slot_count_q == 7'd0 && sub_col_q == 4'd0 && sub_row_q == 4'd0,
		"frame end did not restart slots")
	`SSP_ASSERT_NEXT(a_slot_hold, accept && !last_pix, $stable(slot_count_q),
		"slot count moved inside a subtile")

endmodule

### design/ssp_outbuf.sv
// ----------------------------------------------------------------------------
// Sprite subtile packer result stage
// Forms write addresses and flags into a result register with skid slot.
// ----------------------------------------------------------------------------
`include "sprite_subtile_packer_defines.svh"

module ssp_outbuf (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  logic [31:0]    pixel,
	input  ssp_pkg::step_t step,
	output logic           in_ready,
	ssp_res_if.source      res
);

	ssp_pkg::result_t nxt, main_q, skid_q;
	logic             main_valid_q, skid_valid_q, pop;
	ssp_pkg::addr_t   frame_base, slot_off, pix_off;

	assign frame_base = ssp_pkg::addr_t'(step.frame_count)
		<< (ssp_pkg::BAND_SHIFT + int'(step.size_code));
	assign slot_off   = (ssp_pkg::addr_t'(step.slot_count[6:3]) << ssp_pkg::BAND_SHIFT)
		+ (ssp_pkg::addr_t'(step.slot_count[2:0]) << ssp_pkg::SLOT_SHIFT);
	assign pix_off    = (ssp_pkg::addr_t'(step.pix_row) << ssp_pkg::ROW_SHIFT)
		+ ssp_pkg::addr_t'(step.pix_col);

	always_comb begin
		nxt.pix_addr  = frame_base + slot_off + pix_off;
		nxt.pix_data  = pixel;
		nxt.pix_write = step.has_slot;
		nxt.idx_addr  = (ssp_pkg::iaddr_t'(step.frame_count) << 4)
			+ ssp_pkg::iaddr_t'(step.slot_count);
		nxt.idx_byte  = {step.sub_row, step.sub_col};
		nxt.idx_write = step.keep;
		nxt.dropped   = step.drop;
		nxt.frame_end = step.frame_done;
	end

	assign pop      = main_valid_q & res.ready;
	assign in_ready = ~skid_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (pop) begin
				skid_valid_q <= 1'b0;
			end
		end else if (push && main_valid_q && !pop) begin
			skid_valid_q <= 1'b1;
		end else if (push) begin
			main_valid_q <= 1'b1;
		end else if (pop) begin
			main_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop) begin
				main_q <= skid_q;
			end
		end else if (push && main_valid_q && !pop) begin
			skid_q <= nxt;
		end else if (push) begin
			main_q <= nxt;
		end
	end

	assign res.valid     = main_valid_q;
	assign res.pix_addr  = main_q.pix_addr;
	assign res.pix_data  = main_q.pix_data;
	assign res.pix_write = main_q.pix_write;
	assign res.idx_addr  = main_q.idx_addr;
	assign res.idx_byte  = main_q.idx_byte;
	assign res.idx_write = main_q.idx_write;
	assign res.dropped   = main_q.dropped;
	assign res.frame_end = main_q.frame_end;

	`SSP_ASSERT_NOW(a_skid_needs_main, skid_valid_q, main_valid_q,
		"skid slot full with result register empty")
	`SSP_ASSERT_NEXT(a_skid_drains, skid_valid_q && pop, main_valid_q && !skid_valid_q,
		"skid beat not moved to result register")
	`SSP_ASSERT_NEXT(a_push_lands, push, main_valid_q,
		"accepted beat produced no result")

endmodule

### design/sprite_subtile_packer.sv
// ----------------------------------------------------------------------------
// Sprite subtile packer
// Turns a frame/subtile/row-major pixel stream into slot-packed write beats.
// ----------------------------------------------------------------------------
// One result beat per pixel beat. A pixel is taken every clock while the
// output side keeps up; its result is registered into the result register
// or, when the output stalls, into a one-beat skid slot that keeps input
// ready for that beat. All per-pixel work is counter compares and shifted
// adds, done combinationally. The user must write registers only between
// frames while the stream is idle; the block itself does not enforce this.
module sprite_subtile_packer (
	input  logic       clk,
	input  logic       arst_n,
	ssp_pix_if.sink    pix_in,
	ssp_res_if.source  res_out,
	ssp_cfg_if.sink    cfg
);

	ssp_pkg::cfg_t  regs;
	ssp_pkg::step_t step;
	logic           in_ready, accept;

	assign pix_in.ready = in_ready;
	assign accept       = pix_in.valid & in_ready;

	ssp_cfg_regs u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	ssp_track u_track (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.pixel  (pix_in.pixel),
		.regs   (regs),
		.step   (step)
	);

	ssp_outbuf u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (accept),
		.pixel    (pix_in.pixel),
		.step     (step),
		.in_ready (in_ready),
		.res      (res_out)
	);

endmodule
